/* design/imlc_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// imlc_pkg
// Shared types and constants of the IR module link controller.
// ---------------------------------------------------------------------------
package imlc_pkg;

   // request type codes
   localparam logic [1:0] REQ_RX_BYTE = 2'd0;
   localparam logic [1:0] REQ_TICK    = 2'd1;
   localparam logic [1:0] REQ_SEND    = 2'd2;

   // result kind codes
   localparam logic OUT_KIND_TX = 1'b0;
   localparam logic OUT_KIND_RX = 1'b1;

   // configuration register indexes
   localparam logic CSR_MODULE_ADDRESS = 1'b0;
   localparam logic CSR_REPEAT_INTERVAL = 1'b1;

   localparam int unsigned CSR_DATA_W = 10;

   localparam logic [7:0] CMD_SEND_NEC   = 8'hF1;
   localparam logic [9:0] INTERVAL_RESET = 10'd110;
   localparam logic [9:0] ELAPSED_MAX    = 10'd1023;
   localparam logic [7:0] ACKS_MAX       = 8'd255;

   // byte positions within a command frame
   localparam logic [2:0] BYTE_ADDR = 3'd0;
   localparam logic [2:0] BYTE_CMD  = 3'd1;
   localparam logic [2:0] BYTE_HI   = 3'd2;
   localparam logic [2:0] BYTE_LO   = 3'd3;
   localparam logic [2:0] BYTE_KEY  = 3'd4;

   typedef struct packed {
      logic [1:0] req_type;
      logic [7:0] rx_byte;
      logic [7:0] user_code_high;
      logic [7:0] user_code_low;
      logic [7:0] key_value;
      logic [7:0] extra_frames;
   } req_item_type;

   typedef struct packed {
      logic       out_kind;
      logic [7:0] tx_byte;
      logic       frame_last;
      logic [7:0] rx_user_high;
      logic [7:0] rx_user_low;
      logic [7:0] rx_key;
   } rsp_item_type;

   typedef enum logic {
      JOB_TX,
      JOB_RX
   } job_kind_type;

   // one unit of back-end work: a command frame or a receive report
   typedef struct packed {
      job_kind_type kind;
      logic [7:0]   addr;
      logic [7:0]   b_hi;
      logic [7:0]   b_lo;
      logic [7:0]   b_key;
   } job_type;

   typedef struct packed {
      logic    valid;
      job_type job;
   } job_slot_type;

   typedef struct packed {
      logic       busy;
      logic [2:0] idx;
   } back_status_type;

endpackage

/* design/imlc_front.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// imlc_front
// Accepts items, keeps link state and configuration, queues back-end jobs.
// ---------------------------------------------------------------------------
module imlc_front
   import imlc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic                  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic                  req_valid,
   input  logic                  req_ready,
   input  req_item_type          req_item,
   output job_slot_type          push
);

   logic [7:0]  module_address_ff, module_address_in;
   logic [9:0]  interval_ff, interval_in;
   logic [7:0]  acks_ff, acks_in;
   logic [7:0]  hold_ff [2];
   logic [7:0]  hold_in [2];
   logic [1:0]  fill_ff, fill_in;
   logic        armed_ff, armed_in;
   logic [7:0]  left_ff, left_in;
   logic [23:0] codes_ff, codes_in;
   logic [9:0]  elapsed_ff, elapsed_in;

   logic [7:0]  acks_inc;
   logic [9:0]  elapsed_inc;

   assign acks_inc    = (acks_ff == ACKS_MAX) ? acks_ff : acks_ff + 8'd1;
   assign elapsed_inc = (elapsed_ff == ELAPSED_MAX) ? elapsed_ff : elapsed_ff + 10'd1;

   always_comb begin
      module_address_in = module_address_ff;
      interval_in       = interval_ff;
      acks_in           = acks_ff;
      hold_in           = hold_ff;
      fill_in           = fill_ff;
      armed_in          = armed_ff;
      left_in           = left_ff;
      codes_in          = codes_ff;
      elapsed_in        = elapsed_ff;
      push              = '0;

      if (csr_we) begin
         case (csr_index)
            CSR_MODULE_ADDRESS:  module_address_in = csr_wdata[7:0];
            CSR_REPEAT_INTERVAL: interval_in = csr_wdata[9:0];
            default: ;
         endcase
      end

      if (req_valid && req_ready) begin
         case (req_item.req_type)
            REQ_RX_BYTE: begin
               if (acks_ff != 8'd0) begin
                  acks_in = acks_ff - 8'd1;       // echo of a sent frame
               end else if (fill_ff != 2'd2) begin
                  hold_in[fill_ff[0]] = req_item.rx_byte;
                  fill_in = fill_ff + 2'd1;
               end else begin
                  push.valid     = 1'b1;
                  push.job.kind  = JOB_RX;
                  push.job.addr  = 8'd0;
                  push.job.b_hi  = hold_ff[0];
                  push.job.b_lo  = hold_ff[1];
                  push.job.b_key = req_item.rx_byte;
                  fill_in        = 2'd0;
               end
            end
            REQ_TICK: begin
               elapsed_in = elapsed_inc;
               if (armed_ff && (elapsed_inc >= interval_ff)) begin
                  push.valid = 1'b1;
                  push.job.kind = JOB_TX;
                  push.job.addr = module_address_ff;
                  {push.job.b_hi, push.job.b_lo, push.job.b_key} = codes_ff;
                  acks_in = acks_inc;
                  if (left_ff == 8'd0) begin
                     armed_in = 1'b0;
                  end else begin
                     left_in    = left_ff - 8'd1;
                     elapsed_in = 10'd0;
                  end
               end
            end
            REQ_SEND: begin
               push.valid     = 1'b1;
               push.job.kind  = JOB_TX;
               push.job.addr  = module_address_ff;
               push.job.b_hi  = req_item.user_code_high;
               push.job.b_lo  = req_item.user_code_low;
               push.job.b_key = req_item.key_value;
               acks_in        = acks_inc;
               if (req_item.extra_frames != 8'd0) begin
                  armed_in   = 1'b1;
                  left_in    = req_item.extra_frames - 8'd1;
                  codes_in   = {req_item.user_code_high, req_item.user_code_low,
                                req_item.key_value};
                  elapsed_in = 10'd0;
               end else begin
                  armed_in = 1'b0;
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         module_address_ff <= 8'd0;
         interval_ff       <= INTERVAL_RESET;
         acks_ff           <= 8'd0;
         fill_ff           <= 2'd0;
         armed_ff          <= 1'b0;
         left_ff           <= 8'd0;
         elapsed_ff        <= 10'd0;
      end else begin
         module_address_ff <= module_address_in;
         interval_ff       <= interval_in;
         acks_ff           <= acks_in;
         fill_ff           <= fill_in;
         armed_ff          <= armed_in;
         left_ff           <= left_in;
         elapsed_ff        <= elapsed_in;
      end
   end

   always_ff @(posedge clock) begin
      hold_ff  <= hold_in;
      codes_ff <= codes_in;
   end

endmodule

/* design/imlc_queue.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// imlc_queue
// Small job FIFO between the front and back ends.
// ---------------------------------------------------------------------------
module imlc_queue
   import imlc_pkg::*;
#(
   parameter int unsigned DEPTH = 4
)
(
   input  logic         clock,
   input  logic         reset,
   input  job_slot_type push,
   input  logic         pop,
   output job_slot_type head,
   output logic         full
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   job_type           mem_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              do_push, do_pop;

   assign full       = (count_ff == CNT_FULL);
   assign head.valid = (count_ff != '0);
   assign head.job   = mem_ff[rd_ptr_ff];
   assign do_push    = push.valid && !full;
   assign do_pop     = pop && head.valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push.job;
      end
   end

endmodule

/* design/imlc_back.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// imlc_back
// Serializes queued jobs into result items through an output register.
// ---------------------------------------------------------------------------
module imlc_back
   import imlc_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  job_slot_type    head,
   output logic            pop,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_item_type    rsp_item,
   output back_status_type status
);

   logic         busy_ff, busy_in;
   logic [2:0]   idx_ff, idx_in;
   job_type      cur_ff, cur_in;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_item_type rsp_item_ff, rsp_item_in;
   logic         load;

   function automatic rsp_item_type tx_result(job_type j, logic [2:0] idx);
      rsp_item_type r;
      r            = '0;
      r.out_kind   = OUT_KIND_TX;
      r.frame_last = (idx == BYTE_KEY);
      case (idx)
         BYTE_ADDR: r.tx_byte = j.addr;
         BYTE_CMD:  r.tx_byte = CMD_SEND_NEC;
         BYTE_HI:   r.tx_byte = j.b_hi;
         BYTE_LO:   r.tx_byte = j.b_lo;
         default:   r.tx_byte = j.b_key;
      endcase
      return r;
   endfunction

   assign load = !rsp_valid_ff || rsp_ready;
   assign pop  = load && !busy_ff && head.valid;

   always_comb begin
      busy_in      = busy_ff;
      idx_in       = idx_ff;
      cur_in       = cur_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_item_in  = rsp_item_ff;
      if (load) begin
         if (busy_ff) begin
            rsp_valid_in = 1'b1;
            rsp_item_in  = tx_result(cur_ff, idx_ff);
            if (idx_ff == BYTE_KEY) begin
               busy_in = 1'b0;
            end else begin
               idx_in = idx_ff + 3'd1;
            end
         end else if (head.valid) begin
            rsp_valid_in = 1'b1;
            if (head.job.kind == JOB_RX) begin
               rsp_item_in.out_kind     = OUT_KIND_RX;
               rsp_item_in.tx_byte      = 8'd0;
               rsp_item_in.frame_last   = 1'b1;
               rsp_item_in.rx_user_high = head.job.b_hi;
               rsp_item_in.rx_user_low  = head.job.b_lo;
               rsp_item_in.rx_key       = head.job.b_key;
            end else begin
               rsp_item_in = tx_result(head.job, BYTE_ADDR);
               cur_in      = head.job;
               busy_in     = 1'b1;
               idx_in      = BYTE_CMD;
            end
         end else begin
            rsp_valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         idx_ff       <= BYTE_ADDR;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_item    = rsp_item_ff;
   assign status.busy = busy_ff;
   assign status.idx  = idx_ff;

endmodule

/* design/ir_module_link_controller.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ir_module_link_controller
// Host-side link controller for a serial IR transceiver module.
// ---------------------------------------------------------------------------
//  channel   ports                                   direction
//  req       req_valid / req_ready / req_item        in  (rx byte, ms tick, send)
//  rsp       rsp_valid / rsp_ready / rsp_item        out (tx byte or rx frame)
//  csr       csr_we / csr_index / csr_wdata          in  (write only, no wait)
//
//  The front end takes one item per cycle while the job queue has room and
//  updates all link state in that cycle. The back end drains jobs through the
//  output register: a receive report yields one result item, a command frame
//  five (one per byte); no new job is popped until a frame's last byte is loaded.
//  Reset is synchronous and clears all control state; no clearing pass.
//  A stalled rsp side fills the QUEUE_DEPTH-entry queue, then req_ready drops.
// ---------------------------------------------------------------------------
module ir_module_link_controller
   import imlc_pkg::*;
#(
   parameter int unsigned QUEUE_DEPTH = 4
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic                  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_item_type          req_item,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_item_type          rsp_item
);

   job_slot_type    push;
   job_slot_type    head;
   logic            pop;
   logic            q_full;
   back_status_type back_status;

   // front accepts whenever the queue can hold a possible job
   assign req_ready = !q_full;

   imlc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_item  (req_item),
      .push      (push)
   );

   imlc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (pop),
      .head  (head),
      .full  (q_full)
   );

   imlc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item),
      .status    (back_status)
   );

   // a job is only produced for an accepted item, so never into a full queue
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push.valid |-> !q_full)
      else $error("job pushed into full queue");

   // a frame byte other than the last means the serializer still owns a frame
   a_mid_frame_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_item.frame_last) |-> back_status.busy)
      else $error("mid-frame byte without active frame");

   // popping a command frame starts the serializer at the second byte
   a_tx_pop_starts: assert property (@(posedge clock) disable iff (reset)
      (pop && head.job.kind == JOB_TX) |=>
         (back_status.busy && back_status.idx == BYTE_CMD))
      else $error("frame pop did not start serializer");

   // serializer never pulls a new job while a frame is in progress
   a_no_pop_busy: assert property (@(posedge clock) disable iff (reset)
      back_status.busy |-> !pop)
      else $error("pop while frame in progress");

endmodule
